FILE: hw/rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

  // Modulus value loaded by reset (the prime 10^9 + 7).
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  // Status of the exponentiation core as seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

FILE: hw/rtl/modexp_alu.sv
// Shared shift, add and conditional-subtract unit for modular products and division.
module modexp_alu #(
  parameter int MOD_BITS = 30
) (
  input  logic [MOD_BITS-1:0] acc,
  input  logic [MOD_BITS-1:0] addend,
  input  logic [MOD_BITS-1:0] divisor,
  output logic [MOD_BITS-1:0] value,
  output logic                qbit
);

  localparam int SW = MOD_BITS + 2;

  logic [SW-1:0] sum;
  logic [SW-1:0] div_ext;
  logic [SW-1:0] sub1;
  logic [SW-1:0] sub2;

  // Doubling plus addend; below three times the divisor for products and
  // below twice the divisor for division steps.
  assign sum     = {1'b0, acc, 1'b0} + {2'b00, addend};
  assign div_ext = {2'b00, divisor};

  // Two conditional subtractions bring the sum back below the divisor.
  assign qbit  = (sum >= div_ext);
  assign sub1  = qbit ? (sum - div_ext) : sum;
  assign sub2  = (sub1 >= div_ext) ? (sub1 - div_ext) : sub1;
  assign value = sub2[MOD_BITS-1:0];

endmodule

FILE: hw/rtl/modexp_core.sv
// Sequencer for base reduction, Euclid inverse and square-and-multiply.
module modexp_core #(
  parameter int EXP_BITS = 64,
  parameter int MOD_BITS = 30
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [MOD_BITS-1:0]        base_value,
  input  logic signed [EXP_BITS-1:0] exponent,
  input  logic [MOD_BITS-1:0]        modulus,
  input  logic                       out_free,
  output logic [MOD_BITS-1:0]        result,
  output modexp_pkg::core_stat_t     stat
);

  localparam int CW = $clog2(MOD_BITS);
  localparam int XW = MOD_BITS + 2;
  localparam int QW = MOD_BITS + 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_DIV,
    ST_FIX,
    ST_EXP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [MOD_BITS-1:0]      acc_r, acc_nxt;
  logic [MOD_BITS-1:0]      mcand_r, mcand_nxt;
  logic [MOD_BITS-1:0]      mplier_r, mplier_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [MOD_BITS-1:0]      b_r, b_nxt;
  logic [MOD_BITS-1:0]      res_r, res_nxt;
  logic [EXP_BITS-1:0]      mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [MOD_BITS-1:0]      r_r, r_nxt;
  logic signed [XW-1:0]     x_r, x_nxt;
  logic signed [XW-1:0]     y_r, y_nxt;
  logic signed [QW-1:0]     qy_r, qy_nxt;

  logic                     op_bit;
  logic [MOD_BITS-1:0]      alu_addend;
  logic [MOD_BITS-1:0]      alu_divisor;
  logic [MOD_BITS-1:0]      alu_value;
  logic                     alu_qbit;
  logic                     cnt_last;
  logic [EXP_BITS-1:0]      exp_u;
  logic [EXP_BITS-1:0]      mag_in;
  logic signed [QW-1:0]     x_ext;
  logic signed [QW-1:0]     y_ext;
  logic signed [QW-1:0]     qy_step;
  logic signed [QW-1:0]     coef_diff;
  logic signed [XW-1:0]     m_ext;
  logic signed [XW-1:0]     x_fix;

  // Operand selection for the shared unit: one multiplier bit per cycle,
  // or one dividend bit per cycle during a Euclid division.
  assign op_bit      = mplier_r[MOD_BITS-1];
  assign alu_addend  = (state_r == ST_DIV) ? MOD_BITS'(op_bit)
                                           : (op_bit ? mcand_r : '0);
  assign alu_divisor = (state_r == ST_DIV) ? r_r : modulus;

  modexp_alu #(
    .MOD_BITS (MOD_BITS)
  ) u_alu (
    .acc     (acc_r),
    .addend  (alu_addend),
    .divisor (alu_divisor),
    .value   (alu_value),
    .qbit    (alu_qbit)
  );

  assign cnt_last = (cnt_r == CW'(MOD_BITS - 1));

  // Magnitude of the signed exponent; the most negative value maps exactly.
  assign exp_u  = exponent;
  assign mag_in = exp_u[EXP_BITS-1] ? (~exp_u + EXP_BITS'(1)) : exp_u;

  // Quotient times coefficient, built up one quotient bit at a time.
  assign x_ext     = QW'(x_r);
  assign y_ext     = QW'(y_r);
  assign qy_step   = (qy_r <<< 1) + (alu_qbit ? y_ext : '0);
  assign coef_diff = x_ext - qy_step;

  // Final coefficient folded into [0, modulus).
  assign m_ext = $signed({2'b00, modulus});
  assign x_fix = (x_r < 0) ? (x_r + m_ext) : ((x_r >= m_ext) ? (x_r - m_ext) : x_r);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    b_nxt      = b_r;
    res_nxt    = res_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    r_nxt      = r_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    qy_nxt     = qy_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt    = exponent[EXP_BITS-1];
          mag_nxt    = mag_in;
          mplier_nxt = base_value;
          mcand_nxt  = MOD_BITS'(1);
          acc_nxt    = '0;
          cnt_nxt    = '0;
          if (modulus < MOD_BITS'(2)) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        acc_nxt    = alu_value;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r + CW'(1);
        if (cnt_last) begin
          b_nxt   = alu_value;
          res_nxt = MOD_BITS'(1);
          if (neg_r) begin
            r_nxt = alu_value;
            x_nxt = '0;
            y_nxt = XW'(1);
            if (alu_value == '0) begin
              state_nxt = ST_FIX;
            end else begin
              mplier_nxt = modulus;
              acc_nxt    = '0;
              cnt_nxt    = '0;
              qy_nxt     = '0;
              state_nxt  = ST_DIV;
            end
          end else begin
            state_nxt = ST_EXP;
          end
        end
      end
      ST_DIV: begin
        acc_nxt    = alu_value;
        qy_nxt     = qy_step;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r + CW'(1);
        if (cnt_last) begin
          // One Euclid step: remainder becomes the new divisor.
          r_nxt = alu_value;
          x_nxt = y_r;
          y_nxt = coef_diff[XW-1:0];
          if (alu_value == '0) begin
            state_nxt = ST_FIX;
          end else begin
            mplier_nxt = r_r;
            acc_nxt    = '0;
            cnt_nxt    = '0;
            qy_nxt     = '0;
          end
        end
      end
      ST_FIX: begin
        b_nxt     = x_fix[MOD_BITS-1:0];
        state_nxt = ST_EXP;
      end
      ST_EXP: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (mag_r == '0) begin
          state_nxt = ST_DONE;
        end else if (mag_r[0]) begin
          mcand_nxt  = b_r;
          mplier_nxt = res_r;
          state_nxt  = ST_MUL;
        end else begin
          mag_nxt    = mag_r >> 1;
          mcand_nxt  = b_r;
          mplier_nxt = b_r;
          state_nxt  = ST_SQR;
        end
      end
      ST_MUL: begin
        acc_nxt    = alu_value;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r + CW'(1);
        if (cnt_last) begin
          res_nxt = alu_value;
          mag_nxt = mag_r >> 1;
          if (mag_r[EXP_BITS-1:1] != '0) begin
            mcand_nxt  = b_r;
            mplier_nxt = b_r;
            acc_nxt    = '0;
            cnt_nxt    = '0;
            state_nxt  = ST_SQR;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SQR: begin
        acc_nxt    = alu_value;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r + CW'(1);
        if (cnt_last) begin
          b_nxt     = alu_value;
          state_nxt = ST_EXP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and datapath registers; only the state is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    b_r      <= b_nxt;
    res_r    <= res_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    r_r      <= r_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    qy_r     <= qy_nxt;
  end

  assign result    = res_r;
  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = (state_r == ST_DONE);

endmodule

FILE: hw/rtl/modular_exponentiation.sv
// Steps: start, reduction of the base, Euclid divisions and a fix step for a negative
// exponent, then per exponent bit a decision step, a multiply for a set bit and a
// squaring while bits remain, and a finish step that waits for the output register.
// The core holds a single transaction and takes the next only after it has finished.
// Reset (synchronous, active low) clears the sequencer and the output valid and loads
// the modulus with 1000000007.
module modular_exponentiation #(
  parameter int EXP_BITS = 64,
  parameter int MOD_BITS = 30
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [MOD_BITS-1:0]        in_base_value,
  input  logic signed [EXP_BITS-1:0] in_exponent,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [MOD_BITS-1:0]        out_power_result,
  input  logic                       cfg_wr_en,
  input  logic [MOD_BITS-1:0]        cfg_wr_data
);

  logic [MOD_BITS-1:0]    modulus_r, modulus_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MOD_BITS-1:0]    out_result_r, out_result_nxt;
  logic                   start;
  logic                   out_free;
  logic                   load;
  logic [MOD_BITS-1:0]    core_result;
  modexp_pkg::core_stat_t core_stat;

  // Input transaction is taken only while the core is idle.
  assign in_stall = core_stat.busy;
  assign start    = in_valid & ~in_stall;

  // Output register is free when empty or being drained this cycle.
  assign out_free = ~out_valid_r | ~out_stall;
  assign load     = core_stat.done & out_free;

  modexp_core #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .base_value (in_base_value),
    .exponent   (in_exponent),
    .modulus    (modulus_r),
    .out_free   (out_free),
    .result     (core_result),
    .stat       (core_stat)
  );

  // Next values of the configuration and output registers.
  always_comb begin
    modulus_nxt    = cfg_wr_en ? cfg_wr_data : modulus_r;
    out_valid_nxt  = load | (out_valid_r & out_stall);
    out_result_nxt = load ? core_result : out_result_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= modexp_pkg::MODULUS_RESET[MOD_BITS-1:0];
      out_valid_r <= 1'b0;
    end else begin
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_result_r <= out_result_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_result_r;

`ifndef SYNTHESIS
  // An accepted transaction keeps the core busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("core not busy after accepting a transaction");

  // A new result only appears after the core has finished.
  a_result_from_core: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(core_stat.done))
    else $error("output valid rose without a finished computation");
`endif

endmodule

FILE: tb/sv/modular_exponentiation_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the modular exponentiation block with its own power predictor.
module modular_exponentiation_tb;

  localparam int EXP_BITS = 64;
  localparam int MOD_BITS = 30;
  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 11;
  localparam longint MAX_CYCLES = 20_000_000;
  localparam int SUBPHASES = 4;
  localparam int ITEMS_PER_SUBPHASE = 59;
  localparam int HOLD_CYCLES = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [MOD_BITS-1:0] MOD_MAX = '1;
  localparam logic [MOD_BITS-1:0] MOD_PRIME_A = 30'd998244353;
  localparam logic [MOD_BITS-1:0] MOD_NEAR_TOP = 30'd1073741789;
  localparam logic [EXP_BITS-1:0] EXP_MAX_POS = {1'b0, {(EXP_BITS-1){1'b1}}};
  localparam logic [EXP_BITS-1:0] EXP_MOST_NEG = {1'b1, {(EXP_BITS-1){1'b0}}};

  typedef struct packed {
    logic [MOD_BITS-1:0]        base_value;
    logic signed [EXP_BITS-1:0] exponent;
  } power_request_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [MOD_BITS-1:0]        in_base_value = '0;
  logic signed [EXP_BITS-1:0] in_exponent = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [MOD_BITS-1:0]        out_power_result;
  logic                       cfg_wr_en = 1'b0;
  logic [MOD_BITS-1:0]        cfg_wr_data = '0;

  // Testbench state shared between the processes.
  power_request_t      pending_requests[$];
  logic [MOD_BITS-1:0] expected_powers[$];
  logic [MOD_BITS-1:0] modulus_shadow = modexp_pkg::MODULUS_RESET[MOD_BITS-1:0];
  power_request_t      next_request;
  logic                request_taken = 1'b0;
  int                  send_idle_pct = 15;
  int                  recv_idle_pct = 63;
  int                  hold_requests = 0;
  int                  hold_served = 0;
  int                  hold_left = 0;
  int                  requests_submitted = 0;
  int                  requests_accepted = 0;
  int                  results_checked = 0;
  int                  modulus_writes = 0;
  int                  error_count = 0;
  longint              cycle_count = 0;

  modular_exponentiation dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // Free-running clock.
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Product of two reduced residues, reduced again; both are below 2^30, so 64 bits suffice.
  function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] product;
    product = a * b;
    return product % m;
  endfunction

  // Extended Euclid on signed values with truncating division. For a base that shares a
  // factor with the modulus the coefficient is still returned, reduced into [0, m).
  function automatic logic [63:0] bezout_inverse(logic [63:0] a, logic [63:0] m);
    longint g, r, x, y, t, q;
    g = longint'(m);
    r = longint'(a);
    x = 0;
    y = 1;
    while (r != 0) begin
      q = g / r;
      t = g % r;
      g = r;
      r = t;
      t = x - q * y;
      x = y;
      y = t;
    end
    x = x % longint'(m);
    if (x < 0) begin
      x = x + longint'(m);
    end
    return 64'(x);
  endfunction

  // Right-to-left square-and-multiply over the current modulus.
  function automatic logic [MOD_BITS-1:0] expected_power(logic [MOD_BITS-1:0] base_in,
                                                         logic [EXP_BITS-1:0] exp_in,
                                                         logic [MOD_BITS-1:0] modulus_in);
    logic [63:0] m, b, mag, acc;
    m = 64'(modulus_in);
    if (m < 2) begin
      return '0;
    end
    b = 64'(base_in) % m;
    if (exp_in[EXP_BITS-1]) begin
      // The most negative exponent yields a magnitude of exactly 2^(EXP_BITS-1).
      mag = 64'(~exp_in) + 64'd1;
      b = bezout_inverse(b, m);
    end else begin
      mag = 64'(exp_in);
    end
    acc = 64'd1;
    while (mag != 0) begin
      if (mag[0]) begin
        acc = mul_reduce(acc, b, m);
      end
      mag = mag >> 1;
      if (mag != 0) begin
        b = mul_reduce(b, b, m);
      end
    end
    return acc[MOD_BITS-1:0];
  endfunction

  // Offer the next pending transaction once the current one has been taken, idling at random.
  always @(negedge clk) begin
    if (!in_valid || request_taken) begin
      if (rst_n && pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_request = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_base_value <= next_request.base_value;
        in_exponent <= next_request.exponent;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: a long hold-off when one is requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Sample both channels at the rising edge: predict on input, compare on output.
  always @(posedge clk) begin : monitor
    logic [MOD_BITS-1:0] want;
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Run stopped after %0d cycles without draining.", cycle_count);
      $display("TEST FAILED");
      $finish;
    end else begin
      request_taken = rst_n && in_valid && !in_stall;
      if (request_taken) begin
        expected_powers.push_back(expected_power(in_base_value, in_exponent, modulus_shadow));
        requests_accepted++;
      end
      if (rst_n && out_valid && !out_stall) begin
        results_checked++;
        if (expected_powers.size() == 0) begin
          $error("power_result: unexpected transaction, expected none, actual %0d",
                 out_power_result);
          error_count++;
        end else begin
          want = expected_powers.pop_front();
          if (out_power_result !== want) begin
            $error("power_result: expected %0d, actual %0d", want, out_power_result);
            error_count++;
          end
        end
      end
    end
  end

  // Queue one request for the driver.
  task automatic submit(logic [MOD_BITS-1:0] base_in, logic [EXP_BITS-1:0] exp_in);
    power_request_t req;
    req.base_value = base_in;
    req.exponent = exp_in;
    pending_requests.push_back(req);
    requests_submitted++;
  endtask

  // Block until every submitted transaction has been accepted and answered.
  task automatic wait_drained();
    while (requests_accepted != requests_submitted || results_checked < requests_accepted) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Single-cycle register write; the block is idle whenever this is called.
  task automatic write_modulus(logic [MOD_BITS-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    modulus_shadow = value;
    modulus_writes++;
  endtask

  // Moduli: primes, the all-ones composite, powers of two, tiny and random values.
  function automatic logic [MOD_BITS-1:0] pick_modulus();
    case ($urandom_range(7))
      0: return modexp_pkg::MODULUS_RESET[MOD_BITS-1:0];
      1: return MOD_PRIME_A;
      2: return MOD_NEAR_TOP;
      3: return MOD_MAX;
      4: return MOD_BITS'($urandom_range(2, 1000));
      5: return MOD_BITS'(2);
      6: return MOD_BITS'(1) << $urandom_range(1, MOD_BITS - 1);
      default: return MOD_BITS'($urandom_range(2, 32'(MOD_MAX)));
    endcase
  endfunction

  // Bases lean towards zero, all ones, small values, the modulus itself and one above it.
  function automatic logic [MOD_BITS-1:0] pick_base();
    case ($urandom_range(9))
      0: return '0;
      1: return MOD_MAX;
      2: return MOD_BITS'($urandom_range(1, 16));
      3: return modulus_shadow;
      4: return modulus_shadow + MOD_BITS'(1);
      default: return MOD_BITS'($urandom);
    endcase
  endfunction

  // Exponents are mostly short so the run stays quick; a tenth use the full width.
  function automatic logic [EXP_BITS-1:0] pick_exponent();
    int sel;
    int bits;
    logic [63:0] mag;
    sel = $urandom_range(99);
    if (sel >= 90) begin
      return {$urandom, $urandom};
    end
    if (sel < 5) begin
      mag = '0;
    end else begin
      bits = (sel < 70) ? $urandom_range(1, 16) : $urandom_range(17, 40);
      mag = {$urandom, $urandom} >> (64 - bits);
    end
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // Reset, directed cases, then random traffic under three idling patterns.
  initial begin : stimulus
    int mode;
    int sub;
    int n;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases under the reset modulus: zero exponent, zero base, extreme exponents.
    submit('0, '0);
    submit(MOD_MAX, '0);
    submit('0, -64'sd5);
    submit('0, 64'sd7);
    submit(MOD_MAX, 64'sd1);
    submit(30'd2, EXP_MAX_POS);
    submit(30'd3, EXP_MOST_NEG);
    submit(30'd5, -64'sd1);
    submit(30'd1000000007, 64'sd3);
    submit(30'd1000000008, -64'sd2);
    submit(30'd123456789, -64'sd123456789012345);
    submit(30'd1, -64'sd1);
    wait_drained();

    // Composite modulus: bases sharing a factor with it under negative exponents.
    write_modulus(MOD_MAX);
    submit(30'd3, -64'sd1);
    submit(30'd21, -64'sd7);
    submit(MOD_MAX, 64'sd5);
    submit(MOD_MAX - 30'd1, EXP_MAX_POS);
    wait_drained();

    // Smallest legal modulus.
    write_modulus(30'd2);
    submit(30'd3, -64'sd3);
    submit(30'd2, 64'sd5);
    wait_drained();

    // A modulus below two always answers zero.
    write_modulus(30'd1);
    submit(30'd5, 64'sd3);
    submit('0, '0);
    wait_drained();
    write_modulus('0);
    submit(30'd7, -64'sd2);
    submit(MOD_MAX, '0);
    wait_drained();

    // Random traffic: receiver-heavy idling, then sender-heavy, then none.
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 63 : 0;
      recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 15 : 0;
      for (sub = 0; sub < SUBPHASES; sub++) begin
        write_modulus(pick_modulus());
        // With no idling, hold the result side off long enough for the input to back up.
        if (mode == 2 && sub == 0) begin
          hold_requests++;
        end
        for (n = 0; n < ITEMS_PER_SUBPHASE; n++) begin
          submit(pick_base(), pick_exponent());
        end
        wait_drained();
      end
    end

    // Leave the register at its reset value and finish.
    write_modulus(modexp_pkg::MODULUS_RESET[MOD_BITS-1:0]);
    submit(30'd2, 64'sd10);
    wait_drained();

    $display("Checked %0d results from %0d transactions across %0d modulus writes.",
             results_checked, requests_accepted, modulus_writes);
    $display("Idling covered sender-heavy, receiver-heavy and none, plus one long hold-off.");
    if (error_count == 0 && expected_powers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_alu.sv
hw/rtl/modexp_core.sv
hw/rtl/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
